@@ hw/rtl/cspe_pkg.sv @@
// Shared types, constants and helpers for the cross stencil peak erosion block.
// No dependencies; every other file but cspe_ram refers to this package, by scope or by import.
`default_nettype none

package cspe_pkg;

    // Field widths
    localparam int PIX_W  = 16;
    localparam int CFG_W  = 11;
    localparam int GAIN_W = 16;
    localparam int DIM_W  = 13;  // holds any clamped dimension up to 4096

    // Geometry defaults and limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int DIM_MIN        = 3;
    localparam logic [CFG_W-1:0]  FRAME_DIM_RESET = CFG_W'(1024);
    localparam logic [GAIN_W-1:0] GAIN_RESET      = '0;

    // Output queue depth
    localparam int OUTQ_DEPTH = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_EROSION_GAIN = 2'd2;

    // Item modes
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] height_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] height_out;
        logic             frame_last;
    } t_out_item;

    // Per-item control decided when the item is taken
    typedef struct packed {
        logic             pixel;
        logic             emit;
        logic             interior;
        logic             last;
        logic [PIX_W-1:0] height;
    } t_item_ctl;

    // Clamp a programmed dimension to [DIM_MIN, hi]
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input int unsigned hi);
        logic [DIM_W-1:0] r;
        if (v < CFG_W'(DIM_MIN)) begin
            r = DIM_W'(DIM_MIN);
        end else if (32'(v) > hi) begin
            r = DIM_W'(hi);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cspe_ram.sv @@
// Generic simple dual-port RAM: one write port, two registered read ports.
// Depends on nothing.
`default_nettype none

module cspe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2049,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

@@ hw/rtl/cspe_ctrl.sv @@
// Stream control: pending count, emit position, ring write pointer and window addresses.
// Depends on cspe_pkg; its first-stage register feeds cspe_stencil.
`default_nettype none

module cspe_ctrl #(
    parameter int  MAX_WIDTH  = cspe_pkg::MAX_WIDTH_DEF,
    parameter int  MAX_HEIGHT = cspe_pkg::MAX_HEIGHT_DEF,
    localparam int WW         = $clog2(MAX_WIDTH + 1),
    localparam int HW         = $clog2(MAX_HEIGHT + 1),
    localparam int CW         = $clog2(MAX_WIDTH),
    localparam int RW         = $clog2(MAX_HEIGHT),
    localparam int PW         = $clog2(MAX_WIDTH + 2),
    localparam int RING_DEPTH = 2 * MAX_WIDTH + 1,
    localparam int RING_AW    = $clog2(RING_DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_restart,
    input  wire logic [WW-1:0]        i_eff_w,
    input  wire logic [HW-1:0]        i_eff_h,
    input  wire logic [RING_AW-1:0]   i_off_top,
    input  wire logic [RING_AW-1:0]   i_off_right,
    input  wire logic                 i_accept,
    input  wire cspe_pkg::t_in_item   i_item,
    output logic                      o_emit,
    output logic                      o_s1_valid,
    output cspe_pkg::t_item_ctl       o_s1_ctl,
    output logic [RING_AW-1:0]        o_s1_wp,
    output logic [RING_AW-1:0]        o_s1_addr_top,
    output logic [RING_AW-1:0]        o_s1_addr_mid
);

    logic [PW-1:0]      r_pend;
    logic [CW-1:0]      r_emit_col;
    logic [RW-1:0]      r_emit_row;
    logic [RING_AW-1:0] r_wp;

    logic [PW-1:0]      n_pend;
    logic [CW-1:0]      n_emit_col;
    logic [RW-1:0]      n_emit_row;
    logic [RING_AW-1:0] n_wp;

    logic               is_pixel;
    logic               interior;
    logic               last_col;
    logic               last_row;
    logic               emit;
    logic [RING_AW-1:0] addr_top;
    logic [RING_AW-1:0] addr_mid;

    // Ring address a + b, modulo the ring depth (both operands below it)
    function automatic logic [RING_AW-1:0] wrap_add(input logic [RING_AW-1:0] a,
                                                    input logic [RING_AW-1:0] b);
        logic [RING_AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (RING_AW + 1)'(RING_DEPTH)) begin
            s = s - (RING_AW + 1)'(RING_DEPTH);
        end
        return s[RING_AW-1:0];
    endfunction

    // Position of the oldest pending pixel within the frame
    always_comb begin
        is_pixel = (i_item.mode == cspe_pkg::MODE_PIXEL);
        last_col = (WW'(r_emit_col) == i_eff_w - WW'(1));
        last_row = (HW'(r_emit_row) == i_eff_h - HW'(1));
        interior = (r_emit_row != '0) && (HW'(r_emit_row) < i_eff_h - HW'(1))
                && (r_emit_col != '0) && (WW'(r_emit_col) < i_eff_w - WW'(1));
    end

    // Emit decision: a pixel releases the one W places back, a flush drains
    // a pending border pixel, or an interior one whose bottom neighbor has arrived
    always_comb begin
        if (is_pixel) begin
            emit = (r_pend >= PW'(i_eff_w));
        end else begin
            emit = (r_pend != '0) && (!interior || (r_pend > PW'(i_eff_w)));
        end
    end

    // Next counters
    always_comb begin
        n_pend     = r_pend;
        n_emit_col = r_emit_col;
        n_emit_row = r_emit_row;
        n_wp       = r_wp;
        if (is_pixel && !emit) begin
            n_pend = r_pend + PW'(1);
        end else if (!is_pixel && emit) begin
            n_pend = r_pend - PW'(1);
        end
        if (emit) begin
            if (last_col) begin
                n_emit_col = '0;
                n_emit_row = last_row ? '0 : r_emit_row + RW'(1);
            end else begin
                n_emit_col = r_emit_col + CW'(1);
            end
        end
        if (is_pixel) begin
            n_wp = (r_wp == RING_AW'(RING_DEPTH - 1)) ? '0 : r_wp + RING_AW'(1);
        end
    end

    // Window addresses: top neighbor, and right neighbor or the flushed pixel
    always_comb begin
        addr_top = wrap_add(r_wp, i_off_top);
        if (is_pixel) begin
            addr_mid = wrap_add(r_wp, i_off_right);
        end else begin
            addr_mid = wrap_add(r_wp, RING_AW'(RING_DEPTH) - RING_AW'(r_pend));
        end
    end

    assign o_emit = emit;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= '0;
            r_emit_col <= '0;
            r_emit_row <= '0;
            r_wp       <= '0;
            o_s1_valid <= 1'b0;
        end else begin
            o_s1_valid <= i_accept;
            if (i_restart) begin
                r_pend     <= '0;
                r_emit_col <= '0;
                r_emit_row <= '0;
                r_wp       <= '0;
            end else if (i_accept) begin
                r_pend     <= n_pend;
                r_emit_col <= n_emit_col;
                r_emit_row <= n_emit_row;
                r_wp       <= n_wp;
            end
        end
    end

    // First stage payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            o_s1_ctl.pixel    <= is_pixel;
            o_s1_ctl.emit     <= emit;
            o_s1_ctl.interior <= interior;
            o_s1_ctl.last     <= last_col && last_row;
            o_s1_ctl.height   <= i_item.height_in;
            o_s1_wp           <= r_wp;
            o_s1_addr_top     <= addr_top;
            o_s1_addr_mid     <= addr_mid;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cspe_stencil.sv @@
// Pixel window memory and the stencil datapath: neighbor sum, gain multiply, subtract.
// Depends on cspe_pkg and cspe_ram; fed by the first stage of cspe_ctrl.
`default_nettype none

module cspe_stencil #(
    parameter int  MAX_WIDTH  = cspe_pkg::MAX_WIDTH_DEF,
    localparam int RING_DEPTH = 2 * MAX_WIDTH + 1,
    localparam int RING_AW    = $clog2(RING_DEPTH)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [cspe_pkg::GAIN_W-1:0]   i_gain,
    input  wire logic                          i_s1_valid,
    input  wire cspe_pkg::t_item_ctl           i_s1_ctl,
    input  wire logic [RING_AW-1:0]            i_s1_wp,
    input  wire logic [RING_AW-1:0]            i_s1_addr_top,
    input  wire logic [RING_AW-1:0]            i_s1_addr_mid,
    output logic                               o_push,
    output cspe_pkg::t_out_item                o_item
);

    localparam int PIX_W  = cspe_pkg::PIX_W;
    localparam int SUM_W  = PIX_W + 2;
    localparam int PROD_W = SUM_W + cspe_pkg::GAIN_W;

    logic [PIX_W-1:0] rd_top;
    logic [PIX_W-1:0] rd_mid;

    // Stage 2: window data arrives
    logic                r_s2_valid;
    cspe_pkg::t_item_ctl r_s2_ctl;
    logic [PIX_W-1:0]    r_prev1;  // pixel W back from the newest
    logic [PIX_W-1:0]    r_prev2;  // pixel W+1 back

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] c4;
    logic [SUM_W-1:0] diff;
    logic             above;
    logic [PIX_W-1:0] c_sel;

    // Stage 3: multiply
    logic             r_s3_valid;
    logic [PIX_W-1:0] r_s3_c;
    logic [SUM_W-1:0] r_s3_diff;
    logic             r_s3_apply;
    logic             r_s3_last;
    logic [PROD_W-1:0] prod;

    // Stage 4: subtract
    logic             r_s4_valid;
    logic [PIX_W-1:0] r_s4_c;
    logic [PIX_W-1:0] r_s4_drop;
    logic             r_s4_last;

    cspe_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RING_DEPTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_we      (i_s1_valid && i_s1_ctl.pixel),
        .i_waddr   (i_s1_wp),
        .i_wdata   (i_s1_ctl.height),
        .i_raddr_a (i_s1_addr_top),
        .i_raddr_b (i_s1_addr_mid),
        .o_rdata_a (rd_top),
        .o_rdata_b (rd_mid)
    );

    // Neighbor sum against four times the center
    always_comb begin
        sum   = SUM_W'(rd_top) + SUM_W'(r_s2_ctl.height)
              + SUM_W'(r_prev2) + SUM_W'(rd_mid);
        c4    = {r_prev1, 2'b00};
        above = (c4 > sum);
        diff  = c4 - sum;
        c_sel = r_s2_ctl.pixel ? r_prev1 : rd_mid;
    end

    assign prod = PROD_W'(r_s3_diff) * PROD_W'(i_gain);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_s1_valid;
            r_s3_valid <= r_s2_valid && r_s2_ctl.emit;
            r_s4_valid <= r_s3_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_s2_ctl <= i_s1_ctl;
        // center and left follow the right-neighbor reads of earlier pixels
        if (r_s2_valid && r_s2_ctl.pixel) begin
            r_prev1 <= rd_mid;
            r_prev2 <= r_prev1;
        end
        r_s3_c     <= c_sel;
        r_s3_diff  <= diff;
        r_s3_apply <= r_s2_ctl.pixel && r_s2_ctl.interior && above;
        r_s3_last  <= r_s2_ctl.last;
        r_s4_c     <= r_s3_c;
        r_s4_drop  <= r_s3_apply ? prod[PROD_W-1 -: PIX_W] : '0;
        r_s4_last  <= r_s3_last;
    end

    // Drop never exceeds the center, so the difference stays in range
    assign o_push            = r_s4_valid;
    assign o_item.height_out = r_s4_c - r_s4_drop;
    assign o_item.frame_last = r_s4_last;

endmodule

`default_nettype wire

@@ hw/rtl/cspe_outq.sv @@
// Output queue that holds finished results until the downstream side takes them.
// Depends on cspe_pkg for the result item type.
`default_nettype none

module cspe_outq #(
    parameter int  DEPTH = cspe_pkg::OUTQ_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire cspe_pkg::t_out_item  i_item,
    input  wire logic                 i_pop,
    output logic                      o_valid,
    output cspe_pkg::t_out_item       o_item
);

    cspe_pkg::t_out_item r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

@@ hw/rtl/cross_stencil_peak_erosion.sv @@
// Throughput: one item per clock, pixel or flush, sustained while results are taken.
// A released result passes the first-stage register, stencil stages 2, 3 and 4 and the
// output queue; a pixel is released by the pixel one row later, or by a flush.
// o_stall rises when 15 results are in flight or queued (16-entry output queue).
// Reset (synchronous, active low) clears counters, queue and registers to defaults;
// the pixel window is not cleared.
`default_nettype none

module cross_stencil_peak_erosion #(
    parameter int MAX_WIDTH  = cspe_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cspe_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // pixel input
    input  wire logic                              i_valid,
    input  wire cspe_pkg::t_in_item                i_data,
    output logic                                   o_stall,
    // result output
    output logic                                   o_valid,
    output cspe_pkg::t_out_item                    o_data,
    input  wire logic                              i_stall,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cspe_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [cspe_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [cspe_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int HW         = $clog2(MAX_HEIGHT + 1);
    localparam int RING_DEPTH = 2 * MAX_WIDTH + 1;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int CFG_W      = cspe_pkg::CFG_W;
    localparam int DIM_W      = cspe_pkg::DIM_W;
    localparam int Q_DEPTH    = cspe_pkg::OUTQ_DEPTH;
    localparam int USED_W     = $clog2(Q_DEPTH + 1);

    // Ring offsets for the top and right neighbors at a given width
    function automatic logic [RING_AW-1:0] off_top_of(input logic [DIM_W-1:0] w);
        logic [31:0] v;
        v = 32'(RING_DEPTH) - (32'(w) << 1);
        return v[RING_AW-1:0];
    endfunction

    function automatic logic [RING_AW-1:0] off_right_of(input logic [DIM_W-1:0] w);
        logic [31:0] v;
        v = 32'(RING_DEPTH) - 32'(w) + 32'd1;
        return v[RING_AW-1:0];
    endfunction

    localparam logic [DIM_W-1:0] RST_W =
        cspe_pkg::clamp_dim(cspe_pkg::FRAME_DIM_RESET, MAX_WIDTH);
    localparam logic [DIM_W-1:0] RST_H =
        cspe_pkg::clamp_dim(cspe_pkg::FRAME_DIM_RESET, MAX_HEIGHT);

    // Configuration registers
    logic [CFG_W-1:0]            r_frame_width;
    logic [CFG_W-1:0]            r_frame_height;
    logic [cspe_pkg::GAIN_W-1:0] r_gain;
    logic [WW-1:0]               r_eff_w;
    logic [HW-1:0]               r_eff_h;
    logic [RING_AW-1:0]          r_off_top;
    logic [RING_AW-1:0]          r_off_right;

    logic                           cfg_we;
    logic [cspe_pkg::REG_IDX_W-1:0] cfg_idx;
    logic                           restart;
    logic [DIM_W-1:0]               wr_w;
    logic [DIM_W-1:0]               wr_h;

    // Stream handshake and result credits
    logic              in_accept;
    logic              out_pop;
    logic              emit_now;
    logic [USED_W-1:0] r_used;

    // Inter-module
    logic                s1_valid;
    cspe_pkg::t_item_ctl s1_ctl;
    logic [RING_AW-1:0]  s1_wp;
    logic [RING_AW-1:0]  s1_addr_top;
    logic [RING_AW-1:0]  s1_addr_mid;
    logic                outq_push;
    cspe_pkg::t_out_item outq_item;

    // Register write decode
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[cspe_pkg::CFG_ADDR_W-1:2];
    assign restart = cfg_we && ((cfg_idx == cspe_pkg::REG_FRAME_WIDTH)
                             || (cfg_idx == cspe_pkg::REG_FRAME_HEIGHT));
    assign wr_w    = cspe_pkg::clamp_dim(pwdata[CFG_W-1:0], MAX_WIDTH);
    assign wr_h    = cspe_pkg::clamp_dim(pwdata[CFG_W-1:0], MAX_HEIGHT);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= cspe_pkg::FRAME_DIM_RESET;
            r_frame_height <= cspe_pkg::FRAME_DIM_RESET;
            r_gain         <= cspe_pkg::GAIN_RESET;
            r_eff_w        <= RST_W[WW-1:0];
            r_eff_h        <= RST_H[HW-1:0];
            r_off_top      <= off_top_of(RST_W);
            r_off_right    <= off_right_of(RST_W);
        end else if (cfg_we) begin
            case (cfg_idx)
                cspe_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[CFG_W-1:0];
                    r_eff_w       <= wr_w[WW-1:0];
                    r_off_top     <= off_top_of(wr_w);
                    r_off_right   <= off_right_of(wr_w);
                end
                cspe_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[CFG_W-1:0];
                    r_eff_h        <= wr_h[HW-1:0];
                end
                cspe_pkg::REG_EROSION_GAIN: begin
                    r_gain <= pwdata[cspe_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Register read back
    always_comb begin
        case (cfg_idx)
            cspe_pkg::REG_FRAME_WIDTH:  prdata = 32'(r_frame_width);
            cspe_pkg::REG_FRAME_HEIGHT: prdata = 32'(r_frame_height);
            cspe_pkg::REG_EROSION_GAIN: prdata = 32'(r_gain);
            default:                    prdata = '0;
        endcase
    end

    // Credits: results promised but not yet transferred out
    assign in_accept = i_valid && !o_stall;
    assign out_pop   = o_valid && !i_stall;
    assign o_stall   = (r_used >= USED_W'(Q_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if ((in_accept && emit_now) && !out_pop) begin
            r_used <= r_used + USED_W'(1);
        end else if (!(in_accept && emit_now) && out_pop) begin
            r_used <= r_used - USED_W'(1);
        end
    end

    cspe_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (restart),
        .i_eff_w       (r_eff_w),
        .i_eff_h       (r_eff_h),
        .i_off_top     (r_off_top),
        .i_off_right   (r_off_right),
        .i_accept      (in_accept),
        .i_item        (i_data),
        .o_emit        (emit_now),
        .o_s1_valid    (s1_valid),
        .o_s1_ctl      (s1_ctl),
        .o_s1_wp       (s1_wp),
        .o_s1_addr_top (s1_addr_top),
        .o_s1_addr_mid (s1_addr_mid)
    );

    cspe_stencil #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_stencil (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_gain        (r_gain),
        .i_s1_valid    (s1_valid),
        .i_s1_ctl      (s1_ctl),
        .i_s1_wp       (s1_wp),
        .i_s1_addr_top (s1_addr_top),
        .i_s1_addr_mid (s1_addr_mid),
        .o_push        (outq_push),
        .o_item        (outq_item)
    );

    cspe_outq #(
        .DEPTH (Q_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (outq_push),
        .i_item  (outq_item),
        .i_pop   (out_pop),
        .o_valid (o_valid),
        .o_item  (o_data)
    );

    // Credit count never exceeds what the queue can hold
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(Q_DEPTH - 1))
        else $error("result credit count above queue capacity");

    // A queued result always has a credit behind it
    a_credit_backs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_used != '0))
        else $error("result queued without a credit");

    // An item that releases a pixel reaches the queue after the fixed pipeline depth
    a_emit_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && emit_now) |-> ##4 outq_push)
        else $error("released pixel did not reach the output queue");

endmodule

`default_nettype wire

@@ verif/cross_stencil_peak_erosion_test.sv @@
// Self-checking testbench for the cross stencil peak erosion block.
// Depends on cspe_pkg and the cross_stencil_peak_erosion top level.
`timescale 1ns / 1ps

module cross_stencil_peak_erosion_test;
    import cspe_pkg::*;

    localparam int unsigned WIN_DEPTH = 2 * MAX_WIDTH_DEF + 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 150;

    // Register byte addresses; index 3 is not a register
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] A_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] A_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] A_GAIN   = {REG_EROSION_GAIN, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] A_SPARE  = {REG_SPARE, 2'b00};

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;
    typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_RESULT} chk_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] value;   // register data, or the item height
        logic                  mode;
        chk_e                  chk;
        logic [PIX_W-1:0]      want_height;
        logic                  want_last;
    } dir_row_t;

    // DUT ports
    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    t_in_item              i_data  = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_out_item             o_data;
    logic                  i_stall = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state: pixel ring, raster position, emit position, register copies
    logic [PIX_W-1:0]  win_mem [WIN_DEPTH];
    int unsigned       wr_pos, col_pos, row_pos, out_idx;
    logic [CFG_W-1:0]  shadow_width  = FRAME_DIM_RESET;
    logic [CFG_W-1:0]  shadow_height = FRAME_DIM_RESET;
    logic [GAIN_W-1:0] shadow_gain   = GAIN_RESET;

    t_out_item awaited_pixels [$];
    t_out_item oldest_pixel;
    int        mismatch_count = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        hold_off_req = 0;

    // Directed rows on a 3x3 frame; typed results are readable by hand
    dir_row_t dir_rows [31] = '{
        // after reset nothing is pending
        '{ROW_ITEM,  '0,      32'h0000, MODE_FLUSH, CHK_NONE,    16'h0000, 1'b0},
        // geometry below range clamps to 3x3, full gain, unused address ignored
        '{ROW_WRITE, A_WIDTH,  32'd0,    MODE_PIXEL, CHK_NONE,    16'h0000, 1'b0},
        '{ROW_WRITE, A_HEIGHT, 32'd2,    MODE_PIXEL, CHK_NONE,    16'h0000, 1'b0},
        '{ROW_WRITE, A_GAIN,   32'hFFFF, MODE_PIXEL, CHK_NONE,    16'h0000, 1'b0},
        '{ROW_WRITE, A_SPARE,  32'hFFFF, MODE_PIXEL, CHK_NONE,    16'h0000, 1'b0},
        // lone peak in the center, border pixels pass through
        '{ROW_ITEM,  '0,      32'hFFFF, MODE_PIXEL, CHK_NONE,    16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'h0000, MODE_PIXEL, CHK_NONE,    16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'hFFFF, MODE_PIXEL, CHK_NONE,    16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'h0000, MODE_PIXEL, CHK_RESULT,  16'hFFFF, 1'b0},
        '{ROW_ITEM,  '0,      32'hFFFF, MODE_PIXEL, CHK_RESULT,  16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'h0000, MODE_PIXEL, CHK_RESULT,  16'hFFFF, 1'b0},
        '{ROW_ITEM,  '0,      32'h0000, MODE_PIXEL, CHK_RESULT,  16'h0000, 1'b0},
        // center is waiting for its bottom neighbor: flush is dropped
        '{ROW_ITEM,  '0,      32'h0000, MODE_FLUSH, CHK_NONE,    16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'h0000, MODE_PIXEL, CHK_RESULT,  16'h0001, 1'b0},
        '{ROW_ITEM,  '0,      32'h1234, MODE_PIXEL, CHK_RESULT,  16'h0000, 1'b0},
        // drain the bottom row, last pixel flagged, then nothing left
        '{ROW_ITEM,  '0,      32'hFFFF, MODE_FLUSH, CHK_RESULT,  16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'h0000, MODE_FLUSH, CHK_RESULT,  16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'h0000, MODE_FLUSH, CHK_RESULT,  16'h1234, 1'b1},
        '{ROW_ITEM,  '0,      32'h0000, MODE_FLUSH, CHK_NONE,    16'h0000, 1'b0},
        // gain change while the center pixel is pending
        '{ROW_WRITE, A_GAIN,   32'h8000, MODE_PIXEL, CHK_NONE,    16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'h0100, MODE_PIXEL, CHK_PREDICT, 16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'h0200, MODE_PIXEL, CHK_PREDICT, 16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'h0300, MODE_PIXEL, CHK_PREDICT, 16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'h0400, MODE_PIXEL, CHK_PREDICT, 16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'h9000, MODE_PIXEL, CHK_PREDICT, 16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'h0500, MODE_PIXEL, CHK_PREDICT, 16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'h0600, MODE_PIXEL, CHK_PREDICT, 16'h0000, 1'b0},
        '{ROW_WRITE, A_GAIN,   32'h4000, MODE_PIXEL, CHK_NONE,    16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'h0700, MODE_PIXEL, CHK_PREDICT, 16'h0000, 1'b0},
        // geometry write mid-frame drops the pending pixels
        '{ROW_WRITE, A_HEIGHT, 32'd3,    MODE_PIXEL, CHK_NONE,    16'h0000, 1'b0},
        '{ROW_ITEM,  '0,      32'h0000, MODE_FLUSH, CHK_NONE,    16'h0000, 1'b0}
    };

    cross_stencil_peak_erosion u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] raw, input int unsigned hi);
        if (raw < DIM_MIN) return DIM_MIN;
        if (raw > hi) return hi;
        return raw;
    endfunction

    function automatic bit on_interior(input int unsigned idx, input int unsigned w,
                                       input int unsigned h);
        int unsigned r, c;
        r = idx / w;
        c = idx % w;
        return r >= 1 && r + 1 < h && c >= 1 && c + 1 < w;
    endfunction

    function automatic void restart_frame_state();
        wr_pos  = 0;
        col_pos = 0;
        row_pos = 0;
        out_idx = 0;
    endfunction

    // Pixels taken in but not yet emitted, modulo the frame size
    function automatic int unsigned backlog(input int unsigned w, input int unsigned n);
        int unsigned in_idx;
        in_idx = row_pos * w + col_pos;
        if (in_idx >= out_idx) return in_idx - out_idx;
        return n - out_idx + in_idx;
    endfunction

    // Erode (or pass through) the oldest pending pixel and advance the emit position
    function automatic t_out_item emit_oldest(input int unsigned pend, input int unsigned w,
                                              input int unsigned h);
        int unsigned     n, pos, c, s;
        longint unsigned d;
        t_out_item       r;
        n   = w * h;
        pos = (wr_pos + WIN_DEPTH - pend) % WIN_DEPTH;
        c   = 32'(win_mem[pos]);
        r.height_out = PIX_W'(c);
        if (on_interior(out_idx, w, h)) begin
            s = 32'(win_mem[(pos + WIN_DEPTH - w) % WIN_DEPTH])
              + 32'(win_mem[(pos + w) % WIN_DEPTH])
              + 32'(win_mem[(pos + WIN_DEPTH - 1) % WIN_DEPTH])
              + 32'(win_mem[(pos + 1) % WIN_DEPTH]);
            if (4 * c > s) begin
                d = (64'(4 * c - s) * 64'(shadow_gain)) >> 18;
                r.height_out = PIX_W'(c - 32'(d));
            end
        end
        r.frame_last = (out_idx + 1 == n);
        out_idx = (out_idx + 1 == n) ? 0 : out_idx + 1;
        return r;
    endfunction

    // One accepted item; returns 1 when it releases a pixel
    function automatic bit erode_step(input t_in_item it, output t_out_item res);
        int unsigned w, h, n, pend;
        w = eff_dim(shadow_width, MAX_WIDTH_DEF);
        h = eff_dim(shadow_height, MAX_HEIGHT_DEF);
        n = w * h;
        res = '0;
        if (it.mode == MODE_PIXEL) begin
            win_mem[wr_pos] = it.height_in;
            wr_pos = (wr_pos + 1) % WIN_DEPTH;
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h) row_pos = 0;
            end
            pend = backlog(w, n);
            if (pend == 0) pend = n;
            if (pend > w) begin
                res = emit_oldest(pend, w, h);
                return 1'b1;
            end
            return 1'b0;
        end
        // flush: drains only a border pixel or one whose bottom neighbor has arrived
        pend = backlog(w, n);
        if (pend == 0) return 1'b0;
        if (pend <= w && on_interior(out_idx, w, h)) return 1'b0;
        res = emit_oldest(pend, w, h);
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- drivers

    function automatic logic [PIX_W-1:0] random_height();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return PIX_W'($urandom_range(0, 255));
            default: return PIX_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offer one item, wait for the transfer, then log what it releases
    task automatic send_item(input t_in_item it, input chk_e chk, input t_out_item want);
        t_out_item res;
        bit        has;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        has = erode_step(it, res);
        case (chk)
            CHK_PREDICT: if (has) awaited_pixels.push_back(res);
            CHK_RESULT:  awaited_pixels.push_back(want);
            default: ;
        endcase
    endtask

    // Stop offering, let every awaited result arrive, then cover the pipeline latency
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup and access cycle, then the bus returns to idle
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (addr[CFG_ADDR_W-1:2])
            REG_FRAME_WIDTH: begin
                shadow_width = data[CFG_W-1:0];
                restart_frame_state();
            end
            REG_FRAME_HEIGHT: begin
                shadow_height = data[CFG_W-1:0];
                restart_frame_state();
            end
            REG_EROSION_GAIN: shadow_gain = data[GAIN_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] random_dim(input int unsigned hi);
        if ($urandom_range(0, 5) == 0) return CFG_W'($urandom_range(0, 2));
        return CFG_W'($urandom_range(3, hi));
    endfunction

    // One random phase: drain, new settings, raster frames with stray flushes
    task automatic run_phase(input int unsigned p, input int unsigned budget);
        int unsigned w, h, n, fill;
        bit          big;
        t_in_item    it;
        logic [GAIN_W-1:0] gain;
        big = (p == 1);
        wait_drained();
        case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 80; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 80; end
            default: begin idle_pct = 26; stall_pct = 26; end
        endcase
        // widest frame: both registers above range, clamped to the maximum
        if (big) begin
            cfg_write(A_WIDTH, 32'h7FF);
            cfg_write(A_HEIGHT, 32'($urandom_range(1025, 2047)));
        end else if (p != 5) begin
            cfg_write(A_WIDTH, 32'(random_dim(14)));
            cfg_write(A_HEIGHT, 32'(random_dim(10)));
        end
        case ($urandom_range(0, 3))
            0: gain = '0;
            1: gain = '1;
            default: gain = GAIN_W'($urandom_range(0, 65535));
        endcase
        cfg_write(A_GAIN, 32'(gain));
        w = eff_dim(shadow_width, MAX_WIDTH_DEF);
        h = eff_dim(shadow_height, MAX_HEIGHT_DEF);
        n = w * h;
        if (p == 0) hold_off_req = HOLD_OFF_CYCLES;

        for (int unsigned k = 0; k < budget; k++) begin
            // once: sender holds back until the output side is empty
            if (p == 0 && k == budget / 2) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (awaited_pixels.size() != 0);
            end
            it.mode = ($urandom_range(0, 99) < (big ? 40 : 6)) ? MODE_FLUSH : MODE_PIXEL;
            it.height_in = random_height();
            send_item(it, CHK_PREDICT, '0);
        end

        if (!big) begin
            // complete the frame, then flush its bottom row plus one extra
            fill = (n - (row_pos * w + col_pos)) % n;
            it.mode = MODE_PIXEL;
            repeat (fill) begin
                it.height_in = random_height();
                send_item(it, CHK_PREDICT, '0);
            end
            it.mode = MODE_FLUSH;
            repeat (w + 1) begin
                it.height_in = random_height();
                send_item(it, CHK_PREDICT, '0);
            end
        end
    endtask

    // ---------------------------------------------------------------- receiver

    initial begin : rx_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (hold_off_req != 0) begin
                hold_left = hold_off_req - 1;
                hold_off_req = 0;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Compare each result transfer with the oldest awaited pixel
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_pixels.size() == 0) begin
                $error("unexpected result: height_out=%h frame_last=%b",
                       o_data.height_out, o_data.frame_last);
                mismatch_count++;
            end else begin
                oldest_pixel = awaited_pixels.pop_front();
                if (o_data.height_out !== oldest_pixel.height_out) begin
                    $error("height_out: expected %h, got %h",
                           oldest_pixel.height_out, o_data.height_out);
                    mismatch_count++;
                end
                if (o_data.frame_last !== oldest_pixel.frame_last) begin
                    $error("frame_last: expected %b, got %b",
                           oldest_pixel.frame_last, o_data.frame_last);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        t_in_item  it;
        t_out_item want;
        restart_frame_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_WRITE) begin
                wait_drained();
                cfg_write(dir_rows[k].addr, dir_rows[k].value);
            end else begin
                it.mode      = dir_rows[k].mode;
                it.height_in = dir_rows[k].value[PIX_W-1:0];
                want.height_out = dir_rows[k].want_height;
                want.frame_last = dir_rows[k].want_last;
                send_item(it, dir_rows[k].chk, want);
            end
        end

        for (int unsigned p = 0; p < 8; p++) begin
            run_phase(p, (p == 1) ? 40 : 115);
        end

        i_valid <= 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        while (awaited_pixels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/cspe_pkg.sv
hw/rtl/cspe_ram.sv
hw/rtl/cspe_ctrl.sv
hw/rtl/cspe_stencil.sv
hw/rtl/cspe_outq.sv
hw/rtl/cross_stencil_peak_erosion.sv
verif/cross_stencil_peak_erosion_test.sv
